// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion macros used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  `ASSERT_CLK(label, clk, rstn, !(cond), msg)
`endif

// ===== src/dptt_pkg.sv =====
// ----------------------------------------------------------------------------
// dptt_pkg
// Types and constants of the depth preferred transposition table.
// ----------------------------------------------------------------------------
package dptt_pkg;
  localparam logic [2:0] StProbe   = 3'd0;
  localparam logic [2:0] StUpdate  = 3'd1;
  localparam logic [2:0] StFree    = 3'd2;
  localparam logic [2:0] StEvict   = 3'd3;
  localparam logic [2:0] StReject  = 3'd4;
  localparam logic [1:0] KindExact = 2'd0;
  localparam logic [1:0] KindLower = 2'd1;
  localparam logic [1:0] KindUpper = 2'd2;

  // one table entry
  typedef struct packed {
    logic [63:0] key;
    logic [15:0] score;
    logic [7:0]  depth;
    logic [1:0]  kind;
    logic [15:0] move;
  } entry_t;

  // search token passed along the chain of cells
  typedef struct packed {
    logic        hit;
    logic        free;
    logic [7:0]  min_depth;
    entry_t      ent;
  } token_t;

  function automatic logic [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) return 16'h7fff;
    if (v < -17'sd32768) return 16'h8000;
    return v[15:0];
  endfunction
endpackage

// ===== src/depth_preferred_transposition_table.sv =====
// ----------------------------------------------------------------------------
// depth_preferred_transposition_table
// Fully associative position table with depth preferred replacement.
// ----------------------------------------------------------------------------
// Usage: one request per slave transaction on s_axis (probe or store, chosen
// by tuser). One response per request on m_axis. mate_bound is to be written
// by the user through cfg_we_i/cfg_wdata_i only while idle; the block itself
// does not enforce it. Requests are handled one at a time: the search token
// walks the row of cells in SEG_CELLS-wide segments, one segment per cycle,
// and the next request is taken only once the sequencer is idle and the
// response register is free. Reset clears all valid bits at once; no
// clearing pass is needed.
// A stalled m_axis holds the response; s_axis_tready stays low until taken.
// ----------------------------------------------------------------------------
module depth_preferred_transposition_table #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned SEG_CELLS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [14:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key[63:0] depth[71:64] score[87:72] alpha[103:88] beta[119:104]
  // ply[127:120] entry_kind[129:128] move[145:130] zero fill to 152
  input  logic [151:0] s_axis_tdata,
  // command
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found[0] cutoff[1] result_score[17:2] result_move[33:18]
  // result_kind[35:34] store_status[38:36] zero fill to 40
  output logic [39:0]  m_axis_tdata
);
  import dptt_pkg::*;
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned SEG = (SEG_CELLS < ENTRIES) ? SEG_CELLS : ENTRIES;
  localparam int unsigned NSEG = (ENTRIES + SEG - 1) / SEG;
  localparam int unsigned SEG_W = (NSEG > 1) ? $clog2(NSEG) : 1;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_e;
  state_e state_q;

  logic [14:0]  mate_q;
  logic [151:0] req_q;
  logic         cmd_q;
  logic [SEG_W-1:0] seg_q;
  token_t       tok_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q, min_idx_q;
  logic [39:0]  out_q;
  logic         out_v_q;

  logic [63:0] rkey;
  logic [7:0]  rdepth, rply;
  logic signed [15:0] rscore, ralpha, rbeta;
  logic [1:0]  rkind;
  assign rkey   = req_q[63:0];
  assign rdepth = req_q[71:64];
  assign rscore = req_q[87:72];
  assign ralpha = req_q[103:88];
  assign rbeta  = req_q[119:104];
  assign rply   = req_q[127:120];
  assign rkind  = (req_q[129:128] == 2'd3) ? KindUpper : req_q[129:128];

  // cell chain; every segment head takes the token from tok_q, seg_q selects the segment output
  token_t tok_c [ENTRIES+1];
  logic [IDX_W-1:0] hi_c [ENTRIES+1];
  logic [IDX_W-1:0] fi_c [ENTRIES+1];
  logic [IDX_W-1:0] mi_c [ENTRIES+1];
  logic wr;
  logic [IDX_W-1:0] wr_idx;
  entry_t wr_ent;
  token_t seg_out [NSEG];
  logic [IDX_W-1:0] seg_hi [NSEG];
  logic [IDX_W-1:0] seg_fi [NSEG];
  logic [IDX_W-1:0] seg_mi [NSEG];

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      token_t tin;
      logic [IDX_W-1:0] hin, fin, min_i;
      if (g % SEG == 0) begin : g_head
        assign tin = tok_q;
        assign hin = hit_idx_q;
        assign fin = free_idx_q;
        assign min_i = min_idx_q;
      end else begin : g_mid
        assign tin = tok_c[g];
        assign hin = hi_c[g];
        assign fin = fi_c[g];
        assign min_i = mi_c[g];
      end
      dptt_cell #(.IDX_W(IDX_W), .IDX(g)) u_cell (
        .clk_i, .rst_ni, .key_i(rkey), .tok_en_i(1'b1),
        .tok_i(tin), .hit_idx_i(hin), .free_idx_i(fin), .min_idx_i(min_i),
        .tok_o(tok_c[g+1]), .hit_idx_o(hi_c[g+1]), .free_idx_o(fi_c[g+1]),
        .min_idx_o(mi_c[g+1]), .wr_i(wr), .wr_idx_i(wr_idx), .wr_ent_i(wr_ent)
      );
      if ((g % SEG == SEG - 1) || (g == ENTRIES - 1)) begin : g_tail
        assign seg_out[g / SEG] = tok_c[g+1];
        assign seg_hi[g / SEG] = hi_c[g+1];
        assign seg_fi[g / SEG] = fi_c[g+1];
        assign seg_mi[g / SEG] = mi_c[g+1];
      end
    end
  endgenerate
  assign tok_c[0] = tok_q;
  assign hi_c[0] = hit_idx_q;
  assign fi_c[0] = free_idx_q;
  assign mi_c[0] = min_idx_q;

  // mate adjustment
  logic [15:0] sabs, pabs;
  logic signed [15:0] pscore, sadj, padj;
  assign sabs = rscore[15] ? 16'(-rscore) : rscore;
  assign sadj = (sabs >= {1'b0, mate_q}) ?
      sat16(rscore > 0 ? 17'(rscore) + 17'(rply) : 17'(rscore) - 17'(rply)) : rscore;
  assign pscore = tok_q.ent.score;
  assign pabs = pscore[15] ? 16'(-pscore) : pscore;
  assign padj = (pabs >= {1'b0, mate_q}) ?
      sat16(pscore > 0 ? 17'(pscore) - 17'(rply) : 17'(pscore) + 17'(rply)) : pscore;

  // commit decision
  logic [2:0] status;
  logic cut;
  always_comb begin
    if (tok_q.hit) status = (rdepth >= tok_q.ent.depth) ? StUpdate : StReject;
    else if (tok_q.free) status = StFree;
    else status = StEvict;
    cut = (tok_q.ent.kind == KindExact) ||
          (tok_q.ent.kind == KindLower && padj >= rbeta) ||
          (tok_q.ent.kind == KindUpper && padj <= ralpha);
    cut = cut && (tok_q.ent.depth >= rdepth);
  end
  assign wr = (state_q == S_DONE) && cmd_q && (status != StReject);
  always_comb begin
    unique case (status)
      StUpdate: wr_idx = hit_idx_q;
      StFree:   wr_idx = free_idx_q;
      default:  wr_idx = min_idx_q;
    endcase
  end
  assign wr_ent = '{key: rkey, score: sadj, depth: rdepth, kind: rkind,
                    move: req_q[145:130]};

  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mate_q <= 15'd31000;
    end else if (cfg_we_i) begin
      mate_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q <= s_axis_tdata;
      cmd_q <= s_axis_tuser;
    end
  end

  // sequencer: walk segments then respond
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      seg_q <= '0;
      tok_q <= '0;
      hit_idx_q <= '0;
      free_idx_q <= '0;
      min_idx_q <= '0;
      out_q <= '0;
    end else begin
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            state_q <= S_WALK;
            seg_q <= '0;
            tok_q <= '0;
          end
        end
        S_WALK: begin
          tok_q <= seg_out[seg_q];
          hit_idx_q <= seg_hi[seg_q];
          free_idx_q <= seg_fi[seg_q];
          min_idx_q <= seg_mi[seg_q];
          if (32'(seg_q) == NSEG - 1) state_q <= S_DONE;
          else seg_q <= seg_q + 1'b1;
        end
        S_DONE: begin
          state_q <= S_IDLE;
          out_v_q <= 1'b1;
          if (cmd_q) begin
            out_q <= {1'b0, status, 36'd0};
          end else if (tok_q.hit) begin
            out_q <= {1'b0, StProbe, tok_q.ent.kind, tok_q.ent.move,
                      cut ? padj : 16'd0, cut, 1'b1};
          end else begin
            out_q <= '0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_one_busy, clk_i, rst_ni, out_v_q && state_q != S_IDLE, "busy with response")
  `ASSERT_CLK(a_rsp, clk_i, rst_ni, $rose(out_v_q) |-> $past(state_q == S_DONE), "bad order")
  `ASSERT_CLK(a_wr_done, clk_i, rst_ni, wr |-> cmd_q, "write on probe")
endmodule

// ===== src/dptt_cell.sv =====
// ----------------------------------------------------------------------------
// dptt_cell
// One table slot. Looks at the passing token, merges its own match, free and
// depth info, and writes itself when the commit target names it.
// ----------------------------------------------------------------------------
module dptt_cell #(
  parameter int unsigned IDX_W = 6,
  parameter int unsigned IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [63:0]          key_i,
  input  logic                 tok_en_i,
  input  dptt_pkg::token_t     tok_i,
  input  logic [IDX_W-1:0]     hit_idx_i,
  input  logic [IDX_W-1:0]     free_idx_i,
  input  logic [IDX_W-1:0]     min_idx_i,
  output dptt_pkg::token_t     tok_o,
  output logic [IDX_W-1:0]     hit_idx_o,
  output logic [IDX_W-1:0]     free_idx_o,
  output logic [IDX_W-1:0]     min_idx_o,
  input  logic                 wr_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  dptt_pkg::entry_t     wr_ent_i
);
  import dptt_pkg::*;
  localparam logic [IDX_W-1:0] Me = IDX_W'(IDX);

  logic   valid_q;
  entry_t ent_q;
  logic   my_hit;

  assign my_hit = valid_q && (ent_q.key == key_i);

  // merge into token: first hit, first free, first strict minimum
  always_comb begin
    tok_o = tok_i;
    hit_idx_o = hit_idx_i;
    free_idx_o = free_idx_i;
    min_idx_o = min_idx_i;
    if (!tok_i.hit && my_hit) begin
      tok_o.hit = 1'b1;
      tok_o.ent = ent_q;
      hit_idx_o = Me;
    end
    if (!tok_i.free && !valid_q) begin
      tok_o.free = 1'b1;
      free_idx_o = Me;
    end
    if (IDX == 0 || ent_q.depth < tok_i.min_depth) begin
      tok_o.min_depth = ent_q.depth;
      min_idx_o = Me;
    end
    if (!tok_en_i) tok_o.hit = tok_i.hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i && wr_idx_i == Me) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i && wr_idx_i == Me) begin
      ent_q <= wr_ent_i;
    end
  end
endmodule
